[src/ibh_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// ibh_pkg
// Shared types and constants for the indexed binary heap.
// ============================================================================
package ibh_pkg;

    localparam int CAPACITY  = 255;
    localparam int KEY_WIDTH = 32;
    localparam int OBJ_WIDTH = 8;
    localparam int POS_WIDTH = 8;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_PRESENT = 2'd3;

    typedef struct packed {
        logic [1:0]               command;
        logic [OBJ_WIDTH-1:0]     object_index;
        logic signed [31:0]       key_value;
    } in_item_t;

    typedef struct packed {
        logic [OBJ_WIDTH-1:0]     top_object;
        logic signed [31:0]       top_key;
        logic [1:0]               status;
        logic [7:0]               entry_count;
    } out_item_t;

    function automatic logic beats(input logic is_min,
                                   input logic signed [KEY_WIDTH-1:0] a,
                                   input logic signed [KEY_WIDTH-1:0] b);
        beats = is_min ? (a < b) : (a > b);
    endfunction

endpackage

[src/ibh_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// ibh_ram
// Generic synchronous RAM, one write port, one registered read port.
// ============================================================================
module ibh_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/indexed_binary_heap.sv]
`timescale 1ns / 1ps
// ============================================================================
// indexed_binary_heap
// Indexed min/max heap of objects keyed by Q16.16 values.
// Sift up and sift down move one level at a time, reading the key of the parent
// or of both children through the single read port of each memory.
// Throughput: one transaction at a time; the next is accepted only after the
// result is taken.
// Reset: asynchronous; count and present bits clear, order resets to min.
// ============================================================================
module indexed_binary_heap (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ibh_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ibh_pkg::out_item_t   out_data
);
    localparam int KW = ibh_pkg::KEY_WIDTH;
    localparam int OW = ibh_pkg::OBJ_WIDTH;
    localparam int PW = ibh_pkg::POS_WIDTH;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd1;
    localparam logic [4:0] S_UP0   = 5'd2;
    localparam logic [4:0] S_UP1   = 5'd3;
    localparam logic [4:0] S_UP2   = 5'd4;
    localparam logic [4:0] S_UP3   = 5'd5;
    localparam logic [4:0] S_SWP   = 5'd6;
    localparam logic [4:0] S_DN0   = 5'd7;
    localparam logic [4:0] S_DN1   = 5'd8;
    localparam logic [4:0] S_DN2   = 5'd9;
    localparam logic [4:0] S_DN3   = 5'd10;
    localparam logic [4:0] S_DN4   = 5'd11;
    localparam logic [4:0] S_DN5   = 5'd12;
    localparam logic [4:0] S_POP0  = 5'd13;
    localparam logic [4:0] S_POP1  = 5'd14;
    localparam logic [4:0] S_POP2  = 5'd15;
    localparam logic [4:0] S_DONE  = 5'd16;
    localparam logic [4:0] S_UPD0  = 5'd17;
    localparam logic [4:0] S_UPD1  = 5'd18;
    localparam logic [4:0] S_UPD2  = 5'd19;
    localparam logic [4:0] S_POP3  = 5'd20;

    logic [4:0]    state_reg, state_next;
    logic          is_min_reg;
    logic [255:0]  present_reg, present_next;
    logic [7:0]    count_reg, count_next;
    ibh_pkg::in_item_t cmd_reg, cmd_next;
    ibh_pkg::out_item_t res_reg, res_next;
    logic          out_valid_reg, out_valid_next;

    // current moving object, its key and position
    logic [OW-1:0] obj_reg, obj_next;
    logic [KW-1:0] key_reg, key_next;
    logic [PW-1:0] pos_reg, pos_next;
    // partner (parent or chosen child)
    logic [OW-1:0] pobj_reg, pobj_next;
    logic [KW-1:0] pkey_reg, pkey_next;
    logic [PW-1:0] ppos_reg, ppos_next;
    logic [OW-1:0] lobj_reg, lobj_next;
    logic [KW-1:0] lkey_reg, lkey_next;

    // memories
    logic          s_we;  logic [PW-1:0] s_wa, s_ra; logic [OW-1:0] s_wd, s_rd;
    logic          k_we;  logic [OW-1:0] k_wa, k_ra; logic [KW-1:0] k_wd, k_rd;
    logic          p_we;  logic [OW-1:0] p_wa, p_ra; logic [PW-1:0] p_wd, p_rd;

    ibh_ram #(.ADDR_W(PW), .DATA_W(OW)) u_slots (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
    ibh_ram #(.ADDR_W(OW), .DATA_W(KW)) u_keys (
        .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
    ibh_ram #(.ADDR_W(OW), .DATA_W(PW)) u_pos (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    logic [8:0] left_w, right_w;
    assign left_w  = {pos_reg, 1'b0};
    assign right_w = left_w + 9'd1;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        state_next = state_reg; present_next = present_reg; count_next = count_reg;
        cmd_next = cmd_reg; res_next = res_reg; out_valid_next = out_valid_reg;
        obj_next = obj_reg; key_next = key_reg; pos_next = pos_reg;
        pobj_next = pobj_reg; pkey_next = pkey_reg; ppos_next = ppos_reg;
        lobj_next = lobj_reg; lkey_next = lkey_reg;
        s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
        k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd_next = in_data;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                res_next = '0;
                obj_next = cmd_reg.object_index;
                key_next = KW'(cmd_reg.key_value);
                state_next = S_DONE;
                case (cmd_reg.command)
                    ibh_pkg::CMD_INSERT:
                    begin
                        if (cmd_reg.object_index == '0 || present_reg[cmd_reg.object_index])
                        begin
                            res_next.status = ibh_pkg::ST_PRESENT;
                        end
                        else if (32'(count_reg) >= ibh_pkg::CAPACITY)
                        begin
                            res_next.status = ibh_pkg::ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 8'd1;
                            present_next[cmd_reg.object_index] = 1'b1;
                            k_we = 1'b1; k_wa = cmd_reg.object_index;
                            k_wd = KW'(cmd_reg.key_value);
                            pos_next = count_reg + 8'd1;
                            state_next = S_UP0;
                        end
                    end
                    ibh_pkg::CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ibh_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            s_ra = PW'(1);
                            state_next = S_POP0;
                        end
                    end
                    ibh_pkg::CMD_UPDATE:
                    begin
                        if (cmd_reg.object_index == '0 || !present_reg[cmd_reg.object_index])
                        begin
                            res_next.status = ibh_pkg::ST_PRESENT;
                        end
                        else
                        begin
                            k_we = 1'b1; k_wa = cmd_reg.object_index;
                            k_wd = KW'(cmd_reg.key_value);
                            p_ra = cmd_reg.object_index;
                            state_next = S_UPD0;
                        end
                    end
                    default: ;
                endcase
            end
            S_UPD0:
            begin
                pos_next = p_rd;
                state_next = S_UP0;
            end
            // sift up: place obj at pos, compare with parent
            S_UP0:
            begin
                s_we = 1'b1; s_wa = pos_reg; s_wd = obj_reg;
                p_we = 1'b1; p_wa = obj_reg; p_wd = pos_reg;
                if (pos_reg > PW'(1))
                begin
                    s_ra = pos_reg >> 1;
                    state_next = S_UP1;
                end
                else
                begin
                    state_next = (cmd_reg.command == ibh_pkg::CMD_UPDATE) ? S_DN0 : S_DONE;
                end
            end
            S_UP1:
            begin
                pobj_next = s_rd;
                k_ra = s_rd;
                state_next = S_UP2;
            end
            S_UP2:
            begin
                if (ibh_pkg::beats(is_min_reg, key_reg, k_rd))
                begin
                    s_we = 1'b1; s_wa = pos_reg; s_wd = pobj_reg;
                    p_we = 1'b1; p_wa = pobj_reg; p_wd = pos_reg;
                    pos_next = pos_reg >> 1;
                    state_next = S_UP3;
                end
                else
                begin
                    state_next = (cmd_reg.command == ibh_pkg::CMD_UPDATE &&
                                  pos_reg == ppos_reg) ? S_DN0 : S_DONE;
                end
            end
            S_UP3:
            begin
                cmd_next.command = ibh_pkg::CMD_INSERT;
                state_next = S_UP0;
            end
            S_POP0:
            begin
                res_next.top_object = s_rd;
                k_ra = s_rd;
                s_ra = count_reg;
                state_next = S_POP1;
            end
            S_POP1:
            begin
                res_next.top_key = 32'(signed'(k_rd));
                present_next[res_reg.top_object] = 1'b0;
                obj_next = s_rd;
                k_ra = s_rd;
                count_next = count_reg - 8'd1;
                state_next = (count_reg == 8'd1) ? S_DONE : S_POP2;
            end
            S_POP2:
            begin
                key_next = k_rd;
                pos_next = PW'(1);
                state_next = S_POP3;
            end
            S_POP3:
            begin
                cmd_next.command = ibh_pkg::CMD_POP;
                state_next = S_DN0;
            end
            // sift down: obj/key at pos_reg; write then look at children
            S_DN0:
            begin
                s_we = 1'b1; s_wa = pos_reg; s_wd = obj_reg;
                p_we = 1'b1; p_wa = obj_reg; p_wd = pos_reg;
                if (left_w > {1'b0, count_reg})
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    s_ra = left_w[PW-1:0];
                    state_next = S_DN1;
                end
            end
            S_DN1:
            begin
                lobj_next = s_rd;
                k_ra = s_rd;
                s_ra = right_w[PW-1:0];
                state_next = S_DN2;
            end
            S_DN2:
            begin
                lkey_next = k_rd;
                pobj_next = lobj_reg; pkey_next = k_rd; ppos_next = left_w[PW-1:0];
                if (right_w <= {1'b0, count_reg})
                begin
                    pobj_next = s_rd;
                    k_ra = s_rd;
                    state_next = S_DN3;
                end
                else
                begin
                    state_next = S_DN4;
                end
            end
            S_DN3:
            begin
                if (ibh_pkg::beats(is_min_reg, k_rd, lkey_reg))
                begin
                    pkey_next = k_rd; ppos_next = right_w[PW-1:0];
                end
                else
                begin
                    pobj_next = lobj_reg;
                end
                state_next = S_DN4;
            end
            S_DN4:
            begin
                if (ibh_pkg::beats(is_min_reg, pkey_reg, key_reg))
                begin
                    s_we = 1'b1; s_wa = pos_reg; s_wd = pobj_reg;
                    p_we = 1'b1; p_wa = pobj_reg; p_wd = pos_reg;
                    pos_next = ppos_reg;
                    state_next = S_DN5;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DN5:
            begin
                state_next = S_DN0;
            end
            S_DONE:
            begin
                res_next.entry_count = count_reg;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // remember starting position for update's down decision
        if (state_reg == S_UPD0)
        begin
            ppos_next = p_rd;
        end
        if (state_reg == S_DONE)
        begin
            res_next.entry_count = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            is_min_reg    <= 1'b1;
            present_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                is_min_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;  res_reg  <= res_next;
        obj_reg  <= obj_next;  key_reg  <= key_next;  pos_reg  <= pos_next;
        pobj_reg <= pobj_next; pkey_reg <= pkey_next; ppos_reg <= ppos_next;
        lobj_reg <= lobj_next; lkey_reg <= lkey_next;
    end
endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench for the indexed binary heap: directed and random heap commands
// with random stalls, results checked against an in-bench heap predictor.
// ============================================================================
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    ibh_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    ibh_pkg::out_item_t out_data;

    indexed_binary_heap i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // predictor state
    logic               order_min;
    logic [7:0]         slot_obj [0:255];
    logic signed [31:0] obj_key [0:255];
    int                 obj_pos [0:255];
    bit                 obj_in_heap [0:255];
    int                 heap_size;

    ibh_pkg::in_item_t  cmd_queue [$];
    ibh_pkg::out_item_t result_queue [$];
    int                 error_count;
    int                 watchdog;
    bit                 quiet_phase;
    int                 in_gap;
    int                 out_gap;
    int                 pops_seen;
    int                 flags_seen;

    always #5 clk = ~clk;

    function automatic bit outranks(int a, int b);
        logic signed [31:0] ka;
        logic signed [31:0] kb;
        ka = obj_key[slot_obj[a]];
        kb = obj_key[slot_obj[b]];
        return order_min ? (ka < kb) : (ka > kb);
    endfunction

    function automatic void swap_pos(int a, int b);
        logic [7:0] t;
        t = slot_obj[a];
        slot_obj[a] = slot_obj[b];
        slot_obj[b] = t;
        obj_pos[slot_obj[a]] = a;
        obj_pos[slot_obj[b]] = b;
    endfunction

    function automatic void bubble_up(int p);
        while (p > 1 && outranks(p, p / 2))
        begin
            swap_pos(p, p / 2);
            p = p / 2;
        end
    endfunction

    function automatic void bubble_down(int p);
        int l;
        int pick;
        bit done;
        done = 0;
        while (!done && 2 * p <= heap_size)
        begin
            l = 2 * p;
            pick = l;
            if (l + 1 <= heap_size && outranks(l + 1, l))
                pick = l + 1;
            if (!outranks(pick, p))
            begin
                done = 1;
            end
            else
            begin
                swap_pos(pick, p);
                p = pick;
            end
        end
    endfunction

    function automatic ibh_pkg::out_item_t apply_command(ibh_pkg::in_item_t c);
        ibh_pkg::out_item_t r;
        logic [7:0] t;
        int p;
        r = '0;
        r.status = ibh_pkg::ST_OK;
        if (c.command == ibh_pkg::CMD_INSERT)
        begin
            if (c.object_index == 0 || obj_in_heap[c.object_index])
            begin
                r.status = ibh_pkg::ST_PRESENT;
            end
            else if (heap_size >= ibh_pkg::CAPACITY)
            begin
                r.status = ibh_pkg::ST_FULL;
            end
            else
            begin
                heap_size++;
                obj_key[c.object_index] = c.key_value;
                obj_in_heap[c.object_index] = 1;
                slot_obj[heap_size] = c.object_index;
                obj_pos[c.object_index] = heap_size;
                bubble_up(heap_size);
            end
        end
        else if (c.command == ibh_pkg::CMD_POP)
        begin
            if (heap_size == 0)
            begin
                r.status = ibh_pkg::ST_EMPTY;
            end
            else
            begin
                t = slot_obj[1];
                r.top_object = t;
                r.top_key = obj_key[t];
                obj_in_heap[t] = 0;
                if (heap_size == 1)
                begin
                    heap_size = 0;
                end
                else
                begin
                    slot_obj[1] = slot_obj[heap_size];
                    obj_pos[slot_obj[1]] = 1;
                    heap_size--;
                    bubble_down(1);
                end
            end
        end
        else if (c.command == ibh_pkg::CMD_UPDATE)
        begin
            if (c.object_index == 0 || !obj_in_heap[c.object_index])
            begin
                r.status = ibh_pkg::ST_PRESENT;
            end
            else
            begin
                p = obj_pos[c.object_index];
                obj_key[c.object_index] = c.key_value;
                if (p > 1 && outranks(p, p / 2))
                    bubble_up(p);
                else
                    bubble_down(p);
            end
        end
        r.entry_count = heap_size[7:0];
        return r;
    endfunction

    function automatic ibh_pkg::in_item_t make_cmd(logic [1:0] c, logic [7:0] o,
                                                   logic signed [31:0] k);
        ibh_pkg::in_item_t it;
        it.command = c;
        it.object_index = o;
        it.key_value = k;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 7)) - 32'sd3;
            default: return $signed($urandom);
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                result_queue.push_back(apply_command(in_data));
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    in_data  <= cmd_queue.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet_phase && $urandom_range(0, 4) == 0)
                        in_gap <= $urandom_range(1, 3);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        ibh_pkg::out_item_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
            watchdog  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    $error("unexpected result %p", out_data);
                    error_count++;
                end
                else
                begin
                    e = result_queue.pop_front();
                    if (out_data.top_object !== e.top_object)
                    begin
                        $error("top_object expected %0d actual %0d", e.top_object,
                               out_data.top_object);
                        error_count++;
                    end
                    if (out_data.top_key !== e.top_key)
                    begin
                        $error("top_key expected %0d actual %0d", e.top_key,
                               out_data.top_key);
                        error_count++;
                    end
                    if (out_data.status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, out_data.status);
                        error_count++;
                    end
                    if (out_data.entry_count !== e.entry_count)
                    begin
                        $error("entry_count expected %0d actual %0d", e.entry_count,
                               out_data.entry_count);
                        error_count++;
                    end
                    if (e.top_object != 0)
                        pops_seen++;
                    if (e.status != ibh_pkg::ST_OK)
                        flags_seen++;
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                out_gap <= $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (watchdog >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic drain();
        wait (cmd_queue.size() == 0);
        @(posedge clk);
        while (in_valid || result_queue.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_order(logic v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        order_min = v;
    endtask

    task automatic random_phase(int n, int max_obj);
        int i;
        int r;
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                cmd_queue.push_back(make_cmd(ibh_pkg::CMD_INSERT,
                                             8'($urandom_range(1, max_obj)), rand_key()));
            else if (r < 70)
                cmd_queue.push_back(make_cmd(ibh_pkg::CMD_POP, 8'($urandom),
                                             $signed($urandom)));
            else if (r < 92)
                cmd_queue.push_back(make_cmd(ibh_pkg::CMD_UPDATE,
                                             8'($urandom_range(1, max_obj)), rand_key()));
            else if (r < 96)
                cmd_queue.push_back(make_cmd(2'($urandom_range(0, 2)), 8'd0,
                                             $signed($urandom)));
            else
                cmd_queue.push_back(make_cmd(CMD_SPARE, 8'($urandom), $signed($urandom)));
        end
    endtask

    initial
    begin
        int i;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        error_count = 0;
        pops_seen = 0;
        flags_seen = 0;
        quiet_phase = 0;
        order_min = 1'b1;
        heap_size = 0;
        for (i = 0; i < 256; i++)
        begin
            obj_in_heap[i] = 0;
            obj_key[i] = '0;
            obj_pos[i] = 0;
            slot_obj[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        write_order(1'b1);

        // directed: empty pop, extremes, flags, unused code
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_POP, 8'hFF, 32'sh0));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_UPDATE, 8'd5, 32'sh1));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_INSERT, 8'd0, 32'sh1));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_INSERT, 8'd255, 32'sh7FFFFFFF));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_INSERT, 8'd1, 32'sh80000000));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_INSERT, 8'd2, 32'sh0));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_INSERT, 8'd3, 32'sh0));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_INSERT, 8'd2, 32'sh5));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_UPDATE, 8'd255, 32'shFFFF0000));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_UPDATE, 8'd1, 32'sh7FFFFFFF));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_UPDATE, 8'd0, 32'sh0));
        cmd_queue.push_back(make_cmd(CMD_SPARE, 8'hAA, 32'sh55555555));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_POP, 8'd0, 32'sh0));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_POP, 8'd0, 32'sh0));
        drain();
        // order flip with entries in place
        write_order(1'b0);
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_INSERT, 8'd7, 32'sh10000));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_POP, 8'd0, 32'sh0));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_POP, 8'd0, 32'sh0));
        cmd_queue.push_back(make_cmd(ibh_pkg::CMD_POP, 8'd0, 32'sh0));
        drain();

        // fill to capacity, then extra inserts of objects already present, max order
        for (i = 1; i <= 255; i++)
            cmd_queue.push_back(make_cmd(ibh_pkg::CMD_INSERT, i[7:0], rand_key()));
        for (i = 0; i < 4; i++)
            cmd_queue.push_back(make_cmd(ibh_pkg::CMD_INSERT, 8'($urandom_range(1, 255)),
                                         rand_key()));
        random_phase(30, 255);
        drain();

        write_order(1'b1);
        random_phase(60, 40);
        for (i = 0; i < 20; i++)
            cmd_queue.push_back(make_cmd(ibh_pkg::CMD_POP, 8'd0, 32'sh0));
        drain();

        write_order(1'b0);
        random_phase(40, 20);
        drain();

        write_order(1'b1);
        quiet_phase = 1;
        random_phase(40, 30);
        drain();

        $display("Covered %0d pops, %0d flagged results, both heap orders, full heap.",
                 pops_seen, flags_seen);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
